FILE: rtl/sfcr_pkg.sv
// ----------------------------------------------------------------------------
// sfcr_pkg: shared types, constants and font for the character renderer
// Item structs, the command passed from the front to the back, and the
// built-in 5x7 column font.
// ----------------------------------------------------------------------------
package sfcr_pkg;

    localparam int CELL_W     = 6;
    localparam int CELL_H     = 8;
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;
    localparam int MAX_SCALE  = 8;
    localparam int MASK_W     = CELL_W * MAX_SCALE;
    localparam int SCALE_W    = 4;
    localparam int WIDTH_W    = 6;
    localparam int ROW_W      = $clog2(CELL_H);
    localparam int SUB_W      = $clog2(MAX_SCALE);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] PANEL_W_RESET = 8'd128;
    localparam logic [7:0] PANEL_H_RESET = 8'd160;

    // configuration register indexes
    localparam int         CFG_IDX_W   = 1;
    localparam logic [0:0] CFG_PANEL_W = 1'd0;
    localparam logic [0:0] CFG_PANEL_H = 1'd1;

    // character codes with a meaning of their own
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_UC_A    = 8'h41;
    localparam logic [7:0] CH_UC_Z    = 8'h5A;
    localparam logic [7:0] CH_LC_A    = 8'h61;
    localparam logic [7:0] CH_LC_Z    = 8'h7A;
    localparam logic [7:0] CH_CASE    = 8'h20;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_PERIOD  = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_GREATER = 8'h3E;

    // glyph: column 0 is the leftmost, bit 0 of a column is the top row
    typedef logic [0:GLYPH_COLS-1][GLYPH_ROWS-1:0] t_glyph;

    typedef struct packed {
        logic [7:0]  char_code;
        logic        string_start;
        logic [7:0]  start_x;
        logic [7:0]  start_y;
        logic [3:0]  scale;
        logic [15:0] fg_color;
        logic [15:0] bg_color;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         cell_x;
        logic [7:0]         row_y;
        logic [WIDTH_W-1:0] row_width;
        logic [MASK_W-1:0]  row_mask;
        logic [15:0]        fg_out;
        logic [15:0]        bg_out;
        logic               last_row;
    } t_out_item;

    // one drawable cell, as queued between front and back
    typedef struct packed {
        t_glyph             glyph;
        logic [7:0]         x;
        logic [7:0]         y;
        logic [SCALE_W-1:0] scale;
        logic [15:0]        fg;
        logic [15:0]        bg;
    } t_cmd;

    localparam t_glyph FONT_DIGIT [0:9] = '{
        '{7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E}, '{7'h00, 7'h42, 7'h7F, 7'h40, 7'h00},
        '{7'h42, 7'h61, 7'h51, 7'h49, 7'h46}, '{7'h21, 7'h41, 7'h45, 7'h4B, 7'h31},
        '{7'h18, 7'h14, 7'h12, 7'h7F, 7'h10}, '{7'h27, 7'h45, 7'h45, 7'h45, 7'h39},
        '{7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30}, '{7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
        '{7'h36, 7'h49, 7'h49, 7'h49, 7'h36}, '{7'h06, 7'h49, 7'h49, 7'h29, 7'h1E}};

    localparam t_glyph FONT_LETTER [0:25] = '{
        '{7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E}, '{7'h7F, 7'h49, 7'h49, 7'h49, 7'h36},
        '{7'h3E, 7'h41, 7'h41, 7'h41, 7'h22}, '{7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C},
        '{7'h7F, 7'h49, 7'h49, 7'h49, 7'h41}, '{7'h7F, 7'h09, 7'h09, 7'h09, 7'h01},
        '{7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A}, '{7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F},
        '{7'h00, 7'h41, 7'h7F, 7'h41, 7'h00}, '{7'h20, 7'h40, 7'h41, 7'h3F, 7'h01},
        '{7'h7F, 7'h08, 7'h14, 7'h22, 7'h41}, '{7'h7F, 7'h40, 7'h40, 7'h40, 7'h40},
        '{7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F}, '{7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F},
        '{7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E}, '{7'h7F, 7'h09, 7'h09, 7'h09, 7'h06},
        '{7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E}, '{7'h7F, 7'h09, 7'h19, 7'h29, 7'h46},
        '{7'h46, 7'h49, 7'h49, 7'h49, 7'h31}, '{7'h01, 7'h01, 7'h7F, 7'h01, 7'h01},
        '{7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F}, '{7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F},
        '{7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F}, '{7'h63, 7'h14, 7'h08, 7'h14, 7'h63},
        '{7'h07, 7'h08, 7'h70, 7'h08, 7'h07}, '{7'h61, 7'h51, 7'h49, 7'h45, 7'h43}};

    localparam t_glyph GLYPH_COLON   = '{7'h00, 7'h36, 7'h36, 7'h00, 7'h00};
    localparam t_glyph GLYPH_PERIOD  = '{7'h00, 7'h60, 7'h60, 7'h00, 7'h00};
    localparam t_glyph GLYPH_SLASH   = '{7'h20, 7'h10, 7'h08, 7'h04, 7'h02};
    localparam t_glyph GLYPH_MINUS   = '{7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
    localparam t_glyph GLYPH_GREATER = '{7'h00, 7'h41, 7'h22, 7'h14, 7'h08};

    // case-folded font lookup; unknown codes are blank
    function automatic t_glyph font_glyph(input logic [7:0] code);
        logic [7:0] c;
        logic [7:0] li;
        t_glyph     g;
        c = code;
        if (c >= CH_LC_A && c <= CH_LC_Z) begin
            c = c - CH_CASE;
        end
        li = c - CH_UC_A;
        g  = '0;
        case (c) inside
            [CH_0:CH_9]:       g = FONT_DIGIT[c[3:0]];
            [CH_UC_A:CH_UC_Z]: g = FONT_LETTER[li[4:0]];
            CH_COLON:          g = GLYPH_COLON;
            CH_PERIOD:         g = GLYPH_PERIOD;
            CH_SLASH:          g = GLYPH_SLASH;
            CH_MINUS:          g = GLYPH_MINUS;
            CH_GREATER:        g = GLYPH_GREATER;
            default:           g = '0;
        endcase
        return g;
    endfunction

    // six pixels per scaled cell column step
    function automatic logic [WIDTH_W-1:0] cell_width(input logic [SCALE_W-1:0] s);
        return WIDTH_W'({2'b00, s} * WIDTH_W'(CELL_W));
    endfunction

endpackage

FILE: rtl/sfcr_front.sv
// ----------------------------------------------------------------------------
// sfcr_front: string state, clipping and font lookup
// Accepts characters, tracks cursor and latched string settings, and queues
// one command per drawable cell.
// ----------------------------------------------------------------------------
module sfcr_front
    import sfcr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_in_item             i_item,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output t_cmd                 o_q_cmd
);

    logic [7:0]         r_panel_w, r_panel_h;
    logic [7:0]         r_cur_x, r_cur_y;
    logic [SCALE_W-1:0] r_scale;
    logic [15:0]        r_fg, r_bg;
    logic               r_halted;

    logic [7:0]         n_cur_x, n_cur_y;
    logic [SCALE_W-1:0] n_scale;
    logic [15:0]        n_fg, n_bg;
    logic               n_halted;

    logic               accept;
    logic [WIDTH_W-1:0] wid;
    logic [8:0]         right_edge, bottom_edge;
    logic               clip;
    logic               draw;

    assign accept = i_push && !i_q_full;

    always_comb begin
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_scale  = r_scale;
        n_fg     = r_fg;
        n_bg     = r_bg;
        n_halted = r_halted;
        if (i_item.string_start) begin
            n_cur_x  = i_item.start_x;
            n_cur_y  = i_item.start_y;
            n_fg     = i_item.fg_color;
            n_bg     = i_item.bg_color;
            n_scale  = (i_item.scale > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE)
                                                            : i_item.scale;
            n_halted = (i_item.scale == '0);
        end
        wid         = cell_width(n_scale);
        right_edge  = {1'b0, n_cur_x} + {3'b000, wid};
        bottom_edge = {1'b0, n_cur_y} + {2'b00, n_scale, 3'b000};
        clip        = (i_item.char_code == CH_NUL)
                   || (right_edge > {1'b0, r_panel_w})
                   || (bottom_edge > {1'b0, r_panel_h});
        draw        = !n_halted && !clip;
    end

    assign o_q_push      = accept && draw;
    assign o_q_cmd.glyph = font_glyph(i_item.char_code);
    assign o_q_cmd.x     = n_cur_x;
    assign o_q_cmd.y     = n_cur_y;
    assign o_q_cmd.scale = n_scale;
    assign o_q_cmd.fg    = n_fg;
    assign o_q_cmd.bg    = n_bg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_w <= PANEL_W_RESET;
            r_panel_h <= PANEL_H_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PANEL_W: r_panel_w <= i_cfg_data;
                CFG_PANEL_H: r_panel_h <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_scale  <= SCALE_W'(1);
            r_fg     <= '0;
            r_bg     <= '0;
            r_halted <= 1'b1;
        end else if (accept) begin
            r_cur_x  <= draw ? 8'(right_edge) : n_cur_x;
            r_cur_y  <= n_cur_y;
            r_scale  <= n_scale;
            r_fg     <= n_fg;
            r_bg     <= n_bg;
            r_halted <= n_halted || clip;
        end
    end

endmodule

FILE: rtl/sfcr_fifo.sv
// ----------------------------------------------------------------------------
// sfcr_fifo: short command queue between front and back
// Register-based FIFO; output shows the oldest entry while not empty.
// ----------------------------------------------------------------------------
module sfcr_fifo
    import sfcr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/sfcr_back.sv
// ----------------------------------------------------------------------------
// sfcr_back: row sequencer
// Walks a queued cell into the result register one scaled pixel row per cycle while it is popped.
// ----------------------------------------------------------------------------
module sfcr_back
    import sfcr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_q_cmd,
    input  logic      i_q_empty,
    output logic      o_q_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

    t_cmd             r_cmd;
    logic             r_busy;
    logic [ROW_W-1:0] r_row;
    logic [SUB_W-1:0] r_sub;
    logic [7:0]       r_y;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             advance;
    logic             last_sub, last_row;
    logic [MASK_W-1:0] run, mask;
    logic [CELL_H-1:0] colbits;

    assign advance  = r_busy && (!r_out_valid || i_pop);
    assign o_q_pop  = !r_busy && !i_q_empty;
    assign last_sub = (r_sub == SUB_W'(r_cmd.scale - 1'b1));
    assign last_row = (r_row == ROW_W'(CELL_H - 1)) && last_sub;

    // replicate each lit glyph column into a run of scale pixels;
    // the eighth row of a cell is always blank
    always_comb begin
        run     = ~({MASK_W{1'b1}} << r_cmd.scale);
        mask    = '0;
        colbits = '0;
        for (int col = 0; col < GLYPH_COLS; col++) begin
            colbits = {{(CELL_H - GLYPH_ROWS){1'b0}}, r_cmd.glyph[col]};
            if (colbits[r_row]) begin
                mask = mask | (run << (WIDTH_W'(col) * {2'b00, r_cmd.scale}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (advance) begin
            r_out.cell_x    <= r_cmd.x;
            r_out.row_y     <= r_y;
            r_out.row_width <= cell_width(r_cmd.scale);
            r_out.row_mask  <= mask;
            r_out.fg_out    <= r_cmd.fg;
            r_out.bg_out    <= r_cmd.bg;
            r_out.last_row  <= last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_row       <= '0;
            r_sub       <= '0;
            r_y         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_row  <= '0;
                r_sub  <= '0;
                r_y    <= i_q_cmd.y;
            end else if (advance) begin
                r_y <= r_y + 1'b1;
                if (last_sub) begin
                    r_sub <= '0;
                    r_row <= r_row + 1'b1;
                    if (last_row) begin
                        r_busy <= 1'b0;
                    end
                end else begin
                    r_sub <= r_sub + 1'b1;
                end
            end
        end
    end

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

endmodule

FILE: rtl/scaled_font_character_renderer.sv
// ----------------------------------------------------------------------------
// scaled_font_character_renderer: scaled 5x7 font text renderer
// A cell's first row reaches the port via the queue, the back's command register
// and the result register. A drawn character gives 8*scale rows, one per cycle
// from the back's row sequencer while popped; clipped or halted ones draw nothing.
// Synchronous active-low reset: queues empty, no string active, panel 128 x 160.
// ----------------------------------------------------------------------------
module scaled_font_character_renderer
    import sfcr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // character input queue
    input  logic                 push,
    output logic                 full,
    input  t_in_item             i_in_item,
    // pixel row result queue
    output logic                 empty,
    input  logic                 pop,
    output t_out_item            o_out_item,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    // front -> queue -> back
    logic q_push, q_full, q_pop, q_empty;
    t_cmd q_in, q_out;

    // registers are plain flops, so writes never stall
    assign o_cfg_ready = 1'b1;

    // Input side stalls only when the command queue is full; every accepted
    // item updates the string state, even when it draws nothing.
    assign full = q_full;

    // Front: latches string settings, folds case, looks up the glyph and
    // decides whether the cell fits on the panel. Only drawable cells are
    // queued; the cursor moves on by the cell width for each of them.
    sfcr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in)
    );

    // Two-deep queue lets the front keep taking characters while the back
    // is still stepping through the rows of an earlier cell.
    sfcr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    // Back: one scaled pixel row per cycle, while the downstream keeps popping, into a result
    // register, which is refilled in the same cycle that the downstream pops it.
    sfcr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_cmd   (q_out),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_out_item)
    );

endmodule

FILE: rtl/sfcr_checker.sv
// ----------------------------------------------------------------------------
// sfcr_checker: port-level checks for the character renderer
// Watches the result queue and reset behavior at the top-level ports.
// ----------------------------------------------------------------------------
module sfcr_checker
    import sfcr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_out_item
);

    // reset drains both queues
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("result changed while stalled");

    // no foreground pixels beyond the row width
    a_mask_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_out_item.row_mask >> o_out_item.row_width) == '0))
        else $error("mask bits set beyond row width");

    // rows of one cell follow back to back, one panel row apart
    a_next_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_out_item.last_row) |=>
        (!empty && o_out_item.row_y == 8'($past(o_out_item.row_y) + 8'd1)
                && o_out_item.cell_x == $past(o_out_item.cell_x)))
        else $error("cell rows out of sequence");

endmodule

bind scaled_font_character_renderer sfcr_checker u_sfcr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_item (o_out_item)
);

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for scaled_font_character_renderer
// Pushes text characters through the input queue and predicts every pixel row
// the block should produce: font lookup, case folding, scaling, cursor advance,
// clipping at the panel edges, and string halting. Each popped row is checked
// field by field against the oldest prediction. Panel size registers are
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench
    import sfcr_pkg::*;
();

    localparam int STALL_LIMIT = 5000;  // cycles with no accepted item of any kind
    localparam int IDLE_TAIL   = 20;    // settle time for items that draw nothing
    localparam int MAX_REPORTS = 20;
    localparam int IN_W        = $bits(t_in_item);

    // ------------------------------------------------------------------
    // clock, reset and block ports; every input is known from time zero
    // ------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    t_in_item             i_in_item = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    t_out_item            o_out_item;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = '0;

    always #5 i_clk = ~i_clk;

    scaled_font_character_renderer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // renderer state as the bench sees it
    // ------------------------------------------------------------------
    int   panel_w = 128;
    int   panel_h = 160;
    int   cur_x = 0;
    int   cur_y = 0;
    int   cur_scale = 1;
    logic [15:0] cur_fg = '0;
    logic [15:0] cur_bg = '0;
    bit   halted = 1'b1;

    t_out_item pending_rows[$];   // pixel rows still owed by the block

    int send_idle_pct = 0;        // chance the sender skips a cycle
    int recv_idle_pct = 0;        // chance the receiver holds off pop
    int errors = 0;
    int chars_drawn = 0;
    int chars_sent = 0;
    int rows_checked = 0;
    int cfg_writes = 0;

    // 5x7 column font, column 0 in the top byte, bit 0 of a column = top row
    function automatic logic [39:0] font_columns(input logic [7:0] code);
        logic [7:0] c;
        c = code;
        if (c >= "a" && c <= "z") begin
            c = c - 8'h20;
        end
        case (c)
            "0": return 40'h3E5149453E;
            "1": return 40'h00427F4000;
            "2": return 40'h4261514946;
            "3": return 40'h2141454B31;
            "4": return 40'h1814127F10;
            "5": return 40'h2745454539;
            "6": return 40'h3C4A494930;
            "7": return 40'h0171090503;
            "8": return 40'h3649494936;
            "9": return 40'h064949291E;
            "A": return 40'h7E1111117E;
            "B": return 40'h7F49494936;
            "C": return 40'h3E41414122;
            "D": return 40'h7F4141221C;
            "E": return 40'h7F49494941;
            "F": return 40'h7F09090901;
            "G": return 40'h3E4149497A;
            "H": return 40'h7F0808087F;
            "I": return 40'h00417F4100;
            "J": return 40'h2040413F01;
            "K": return 40'h7F08142241;
            "L": return 40'h7F40404040;
            "M": return 40'h7F020C027F;
            "N": return 40'h7F0408107F;
            "O": return 40'h3E4141413E;
            "P": return 40'h7F09090906;
            "Q": return 40'h3E4151215E;
            "R": return 40'h7F09192946;
            "S": return 40'h4649494931;
            "T": return 40'h01017F0101;
            "U": return 40'h3F4040403F;
            "V": return 40'h1F2040201F;
            "W": return 40'h3F4038403F;
            "X": return 40'h6314081463;
            "Y": return 40'h0708700807;
            "Z": return 40'h6151494543;
            ":": return 40'h0036360000;
            ".": return 40'h0060600000;
            "/": return 40'h2010080402;
            "-": return 40'h0808080808;
            ">": return 40'h0041221408;
            default: return 40'h0;
        endcase
    endfunction

    // Queue up the rows one accepted character should produce.
    // Returns -1 when the character is ignored (halted), else the row count.
    function automatic int render_rows(input t_in_item it);
        int          s;
        int          w;
        int          n;
        logic [39:0] g;
        logic [7:0]  colbits;
        logic [47:0] mask;
        logic [47:0] run;
        t_out_item   r;
        if (it.string_start) begin
            cur_x  = it.start_x;
            cur_y  = it.start_y;
            cur_fg = it.fg_color;
            cur_bg = it.bg_color;
            s = it.scale;
            if (s > MAX_SCALE) begin
                s = MAX_SCALE;
            end
            cur_scale = s;
            halted    = (s == 0);
        end
        if (halted) begin
            return -1;
        end
        s = cur_scale;
        w = CELL_W * s;
        // zero code or a cell that would cross an edge ends the string
        if (it.char_code == CH_NUL || cur_x + w > panel_w || cur_y + CELL_H * s > panel_h) begin
            halted = 1'b1;
            return 0;
        end
        g   = font_columns(it.char_code);
        run = (48'd1 << s) - 48'd1;
        n   = 0;
        for (int row = 0; row < CELL_H; row++) begin
            mask = '0;
            for (int col = 0; col < GLYPH_COLS; col++) begin
                colbits = g[39 - 8 * col -: 8];
                if (colbits[row]) begin
                    mask |= run << (col * s);
                end
            end
            for (int sy = 0; sy < s; sy++) begin
                r.cell_x    = 8'(cur_x);
                r.row_y     = 8'(cur_y + row * s + sy);
                r.row_width = WIDTH_W'(w);
                r.row_mask  = mask;
                r.fg_out    = cur_fg;
                r.bg_out    = cur_bg;
                r.last_row  = (row == CELL_H - 1) && (sy == s - 1);
                pending_rows.push_back(r);
                n++;
            end
        end
        cur_x = (cur_x + w) & 8'hFF;
        return n;
    endfunction

    // ------------------------------------------------------------------
    // receiver: pop is re-rolled at every falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string field, input logic [47:0] exp_v,
                                   input logic [47:0] act_v);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
        end
    endtask

    // checker: every popped row against the oldest outstanding prediction
    t_out_item want;
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            rows_checked++;
            if (pending_rows.size() == 0) begin
                report_mismatch("unexpected row", '0, 48'(o_out_item.row_y));
            end else begin
                want = pending_rows.pop_front();
                if (o_out_item.cell_x !== want.cell_x)
                    report_mismatch("cell_x", 48'(want.cell_x), 48'(o_out_item.cell_x));
                if (o_out_item.row_y !== want.row_y)
                    report_mismatch("row_y", 48'(want.row_y), 48'(o_out_item.row_y));
                if (o_out_item.row_width !== want.row_width)
                    report_mismatch("row_width", 48'(want.row_width),
                                    48'(o_out_item.row_width));
                if (o_out_item.row_mask !== want.row_mask)
                    report_mismatch("row_mask", want.row_mask, o_out_item.row_mask);
                if (o_out_item.fg_out !== want.fg_out)
                    report_mismatch("fg_out", 48'(want.fg_out), 48'(o_out_item.fg_out));
                if (o_out_item.bg_out !== want.bg_out)
                    report_mismatch("bg_out", 48'(want.bg_out), 48'(o_out_item.bg_out));
                if (o_out_item.last_row !== want.last_row)
                    report_mismatch("last_row", 48'(want.last_row),
                                    48'(o_out_item.last_row));
            end
        end
    end

    // watchdog: too long without any handshake completing means a hang
    int stall_cycles = 0;
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d rows outstanding",
                     $time, STALL_LIMIT, pending_rows.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // shared drivers; all called and returning at a falling edge
    // ------------------------------------------------------------------
    task automatic send_char(input t_in_item it);
        int rows;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
        end
        push      = 1'b1;
        i_in_item = it;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        rows = render_rows(it);
        chars_sent++;
        if (rows > 0) begin
            chars_drawn++;
        end
        @(negedge i_clk);
        push = 1'b0;
    endtask

    function automatic t_in_item make_item(input logic [7:0] code, input logic start,
                                           input logic [7:0] x, input logic [7:0] y,
                                           input logic [3:0] scale,
                                           input logic [15:0] fg, input logic [15:0] bg);
        t_in_item it;
        it.char_code    = code;
        it.string_start = start;
        it.start_x      = x;
        it.start_y      = y;
        it.scale        = scale;
        it.fg_color     = fg;
        it.bg_color     = bg;
        return it;
    endfunction

    // continuation character: the start fields are don't-care, so randomize them
    function automatic t_in_item next_char(input logic [7:0] code);
        t_in_item it;
        it              = t_in_item'(IN_W'({$urandom(), $urandom()}));
        it.char_code    = code;
        it.string_start = 1'b0;
        return it;
    endfunction

    task automatic wait_results();
        while (pending_rows.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // drained and settled: characters that draw nothing may still be in flight
    task automatic wait_idle();
        wait_results();
        repeat (IDLE_TAIL) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        if (idx == CFG_PANEL_W) begin
            panel_w = data;
        end else begin
            panel_h = data;
        end
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_panel(input logic [7:0] w, input logic [7:0] h);
        wait_idle();
        cfg_write(CFG_PANEL_W, w);
        cfg_write(CFG_PANEL_H, h);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // digits, both cases of letters, every sign and a few codes with no glyph
    task automatic test_font_coverage();
        logic [7:0] codes[$];
        codes = '{"0", "9", "A", "Z", "a", "z", ":", ".", "/", "-", ">", 8'h7F, 8'hFF};
        send_char(make_item(codes[0], 1'b1, 8'd0, 8'd0, 4'd1, 16'hFFFF, 16'h0000));
        for (int i = 1; i < codes.size(); i++) begin
            send_char(next_char(codes[i]));
        end
    endtask

    // zero scale, saturation above the maximum, zero code and halted input
    task automatic test_scale_limits();
        send_char(make_item("A", 1'b1, 8'd0, 8'd0, 4'd0, 16'h1234, 16'h5678));
        send_char(next_char("B"));       // still halted after the rejected start
        send_char(make_item("W", 1'b1, 8'd0, 8'd0, 4'd15, 16'h0000, 16'hFFFF));
        send_char(next_char("m"));       // second full-size cell, ends at x=96
        send_char(next_char(">"));       // would pass x=128: clipped
        send_char(make_item("k", 1'b1, 8'd0, 8'd100, 4'd1, 16'hA5A5, 16'h5A5A));
        send_char(next_char(CH_NUL));    // ends the string
        send_char(next_char("X"));       // ignored
    endtask

    // cells exactly touching the right and bottom edges, a cell past the right edge and one pixel past the bottom
    task automatic test_edge_clipping();
        send_char(make_item("8", 1'b1, 8'd122, 8'd0, 4'd1, 16'hF800, 16'h001F));
        send_char(next_char("8"));
        send_char(make_item("1", 1'b1, 8'd0, 8'd152, 4'd1, 16'h07E0, 16'hFFFF));
        send_char(make_item("1", 1'b1, 8'd0, 8'd153, 4'd1, 16'h07E0, 16'hFFFF));
    endtask

    // smallest and largest panel settings
    task automatic test_panel_extremes();
        set_panel(8'd1, 8'd1);
        send_char(make_item("A", 1'b1, 8'd0, 8'd0, 4'd1, 16'hFFFF, 16'h0000));
        set_panel(8'd255, 8'd255);
        send_char(make_item("Q", 1'b1, 8'd249, 8'd247, 4'd1, 16'h8001, 16'h7FFE));
        send_char(next_char("Q"));
    endtask

    function automatic logic [7:0] pick_char();
        int         r;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 40) begin
            c = 8'("A" + $urandom_range(25));
            if ($urandom_range(1)) c = c + 8'h20;
        end else if (r < 58) begin
            c = 8'("0" + $urandom_range(9));
        end else if (r < 70) begin
            case ($urandom_range(4))
                0: c = CH_COLON;
                1: c = CH_PERIOD;
                2: c = CH_SLASH;
                3: c = CH_MINUS;
                default: c = CH_GREATER;
            endcase
        end else if (r < 96) begin
            c = 8'($urandom_range(1, 255));
        end else begin
            c = CH_NUL;
        end
        return c;
    endfunction

    // Mostly well-formed strings placed to fit the panel, with random content;
    // some starts land anywhere, and a share of items is plain noise.
    task automatic test_random_strings(input int target);
        int       sent_at_start;
        int       budget;
        int       sc;
        int       eff;
        int       len;
        int       xmax;
        int       ymax;
        t_in_item it;
        sent_at_start = chars_sent;
        budget = target * 8;
        while (chars_sent - sent_at_start < target && budget > 0) begin
            // now and then hold the sender until the block has caught up
            if ($urandom_range(99) < 3) begin
                wait_results();
            end
            if ($urandom_range(99) < 12) begin
                send_char(t_in_item'(IN_W'({$urandom(), $urandom()})));
                budget--;
                continue;
            end
            sc = $urandom_range(99);
            if (sc < 4)       sc = 0;
            else if (sc < 70) sc = $urandom_range(1, 2);
            else if (sc < 90) sc = $urandom_range(3, 4);
            else              sc = $urandom_range(5, 15);
            eff  = (sc > MAX_SCALE) ? MAX_SCALE : sc;
            xmax = panel_w - CELL_W * eff;
            ymax = panel_h - CELL_H * eff;
            it = t_in_item'(IN_W'({$urandom(), $urandom()}));
            it.string_start = 1'b1;
            it.scale        = 4'(sc);
            it.char_code    = pick_char();
            if (it.char_code == CH_NUL) it.char_code = "H";
            if ($urandom_range(99) < 80) begin
                it.start_x = 8'((xmax > 0) ? $urandom_range(xmax) : 0);
                it.start_y = 8'((ymax > 0) ? $urandom_range(ymax) : 0);
            end
            send_char(it);
            budget--;
            len = $urandom_range(0, 7);
            for (int i = 0; i < len; i++) begin
                send_char(next_char(pick_char()));
                budget--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // sender idles lightly, receiver heavily
        send_idle_pct = 32;
        recv_idle_pct = 82;
        test_font_coverage();
        test_scale_limits();
        test_edge_clipping();
        test_panel_extremes();
        test_random_strings(110);

        // swap the pressure; random panel size
        send_idle_pct = 82;
        recv_idle_pct = 32;
        set_panel(8'($urandom_range(48, 255)), 8'($urandom_range(64, 255)));
        test_random_strings(110);

        // full rate both ways, back to the reset panel size
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_panel(PANEL_W_RESET, PANEL_H_RESET);
        test_random_strings(120);

        wait_idle();
        if (pending_rows.size() != 0) begin
            errors++;
        end
        $display("summary: %0d characters sent, %0d drawn, %0d pixel rows checked",
                 chars_sent, chars_drawn, rows_checked);
        $display("summary: %0d panel register writes, scales 0..15, edge clips, halts",
                 cfg_writes);
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

FILE: scaled_font_character_renderer.f
rtl/sfcr_pkg.sv
rtl/sfcr_front.sv
rtl/sfcr_fifo.sv
rtl/sfcr_back.sv
rtl/scaled_font_character_renderer.sv
rtl/sfcr_checker.sv
sim/testbench.sv
